### src/sbdc_pkg.sv
// ============================================================================
// sbdc_pkg
// Shared types and constants of the strobed BCD display capture block.
// ============================================================================
package sbdc_pkg;

    localparam int C_FRAME_BYTES = 80;
    localparam int C_CHAR_W      = 8;
    localparam int C_LANES       = 4;
    localparam int C_WORDS       = C_FRAME_BYTES / C_LANES;
    localparam int C_BANKS       = 2;
    localparam int C_ROWS        = C_WORDS / C_BANKS;
    localparam int C_ROW_W       = $clog2(C_ROWS);
    localparam int C_WORD_W      = 5;
    localparam int C_SECOND_OFS  = 20;
    localparam int C_SECOND_WDS  = C_SECOND_OFS / C_LANES;
    localparam int C_TALLY_BYTE  = 72;
    localparam int C_TALLY_WORD  = C_TALLY_BYTE / C_LANES;
    localparam int C_TALLY_LANE  = C_TALLY_BYTE % C_LANES;
    localparam int C_REMAP_LOW   = 40;
    localparam int C_REMAP_MID   = 41;

    localparam logic [3:0] C_POS_LOW   = 4'd0;
    localparam logic [3:0] C_POS_MID   = 4'd8;
    localparam logic [3:0] C_BCD_LIMIT = 4'd10;

    localparam logic [C_CHAR_W-1:0] C_CHAR_SPACE = 8'h20;
    localparam logic [C_CHAR_W-1:0] C_CHAR_ZERO  = 8'h30;
    localparam logic [C_CHAR_W-1:0] C_CHAR_NUL   = 8'h00;

    localparam logic [C_WORD_W-1:0] C_WORD_LAST = C_WORD_W'(C_WORDS - 1);

    typedef struct packed {
        logic [3:0] strobe_number;
        logic       strobe_invalid;
        logic [3:0] digit_first;
        logic [3:0] digit_second;
    } t_sample;

    typedef struct packed {
        logic [31:0]         char_word;
        logic [C_WORD_W-1:0] word_index;
        logic                last_word;
    } t_word;

endpackage

### src/sbdc_if.sv
// ============================================================================
// sbdc_in_if / sbdc_out_if
// Valid/ready channels for bus samples and for frame words.
// ============================================================================
interface sbdc_in_if;
    import sbdc_pkg::*;

    logic    valid;
    logic    ready;
    t_sample data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sbdc_out_if;
    import sbdc_pkg::*;

    logic  valid;
    logic  ready;
    t_word data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### src/sbdc_ram.sv
// ============================================================================
// sbdc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ============================================================================
module sbdc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 10
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### src/strobed_bcd_display_capture_top.sv
// ============================================================================
// strobed_bcd_display_capture_top
// Captures an 80-character frame from a strobed BCD display bus and sends
// each changed frame as 20 four-character words.
// ============================================================================
// Usage:
//   i_sample carries one bus sample per transaction. A sample with a valid
//   strobe writes up to two ASCII digits into the frame store. After a
//   sample the block stays ready for the next one unless it publishes the frame.
//   A publish runs a compare pass over the 10 rows of the frame and shown
//   stores that also copies the frame into the shown store and clears the
//   frame to spaces. If the frame changed, the block then sends 20
//   transactions on o_word, each word read in ST_EMIT_RD and loaded in
//   ST_EMIT_LD; word 18 carries the update counter in its low byte.
//   Compare and emission share the single read port of each store.
//   No sample is taken during a publish; the next one is taken as soon as
//   the last word sits in the output register.
//   A stalled receiver holds the output register and the emission with it.
//   After reset an init pass over the 10 rows fills the frame store with
//   spaces, the shown store with NUL bytes; no sample is taken until it ends.
// ============================================================================
module strobed_bcd_display_capture_top (
    input logic        i_clk,
    input logic        i_rst_n,
    sbdc_in_if.sink    i_sample,
    sbdc_out_if.source o_word
);
    import sbdc_pkg::*;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CMP_RD,
        ST_CMP_WR,
        ST_EMIT_RD,
        ST_EMIT_LD
    } t_state;

    localparam logic [C_ROW_W-1:0]  C_ROW_LAST  = C_ROW_W'(C_ROWS - 1);
    localparam logic [C_WORD_W-1:0] C_GRP       = C_WORD_W'(C_SECOND_WDS);
    localparam logic [C_WORD_W-1:0] C_GRP2      = C_WORD_W'(2 * C_SECOND_WDS);
    localparam logic [C_WORD_W-1:0] C_GRP3      = C_WORD_W'(3 * C_SECOND_WDS);
    localparam logic [C_WORD_W-1:0] C_TALLY_WD  = C_WORD_W'(C_TALLY_WORD);
    localparam logic [C_ROW_W-1:0]  C_REMAP_ROW =
        C_ROW_W'(C_REMAP_LOW / C_LANES - C_SECOND_WDS);
    localparam logic [1:0] C_LANE_LOW = 2'(C_REMAP_LOW % C_LANES);
    localparam logic [1:0] C_LANE_MID = 2'(C_REMAP_MID % C_LANES);

    t_state                r_state;
    logic [C_ROW_W-1:0]    r_row;
    logic [C_WORD_W-1:0]   r_word;
    logic                  r_diff;
    logic                  r_valid_prev;
    logic [7:0]            r_tally;
    logic                  r_dirty;
    logic [7:0]            r_update_tally;
    logic                  r_out_valid;
    t_word                 r_out;

    t_sample               smp;
    logic                  in_accept;
    logic                  smp_valid;
    logic [3:0]            pos;
    logic [C_ROW_W-1:0]    smp_row;
    logic [1:0]            smp_lane;
    logic                  bcd_first;
    logic                  bcd_second;
    logic [7:0]            n_tally;
    logic [C_ROW_W-1:0]    emit_row;
    logic                  emit_bank;
    logic [C_ROW_W-1:0]    rd_row;
    logic [C_ROW_W-1:0]    wr_row;
    logic                  n_diff;
    logic                  out_free;
    logic [C_LANES-1:0][C_CHAR_W-1:0] emit_data;

    logic [C_BANKS-1:0][C_LANES-1:0]               frame_we;
    logic [C_BANKS-1:0][C_LANES-1:0]               shown_we;
    logic [C_BANKS-1:0][C_LANES-1:0][C_CHAR_W-1:0] frame_wdata;
    logic [C_BANKS-1:0][C_LANES-1:0][C_CHAR_W-1:0] shown_wdata;
    logic [C_BANKS-1:0][C_LANES-1:0][C_CHAR_W-1:0] frame_rdata;
    logic [C_BANKS-1:0][C_LANES-1:0][C_CHAR_W-1:0] shown_rdata;

    assign smp            = i_sample.data;
    assign i_sample.ready = (r_state == ST_IDLE);
    assign in_accept      = i_sample.valid && i_sample.ready;
    assign o_word.valid   = r_out_valid;
    assign o_word.data    = r_out;
    assign out_free       = !r_out_valid || o_word.ready;

    assign smp_valid  = !smp.strobe_invalid;
    assign pos        = ~smp.strobe_number;
    assign bcd_first  = smp.digit_first < C_BCD_LIMIT;
    assign bcd_second = smp.digit_second < C_BCD_LIMIT;
    assign n_tally    = r_tally + 8'(smp_valid != r_valid_prev);
    assign n_diff     = r_diff || (frame_rdata != shown_rdata);

    always_comb begin
        priority if (pos == C_POS_LOW) begin
            smp_row  = C_REMAP_ROW;
            smp_lane = C_LANE_LOW;
        end else if (pos == C_POS_MID) begin
            smp_row  = C_REMAP_ROW;
            smp_lane = C_LANE_MID;
        end else begin
            smp_row  = C_ROW_W'(pos[3:2]);
            smp_lane = pos[1:0];
        end
    end

    always_comb begin
        priority if (r_word < C_GRP) begin
            emit_row  = C_ROW_W'(r_word);
            emit_bank = 1'b0;
        end else if (r_word < C_GRP2) begin
            emit_row  = C_ROW_W'(r_word - C_GRP);
            emit_bank = 1'b1;
        end else if (r_word < C_GRP3) begin
            emit_row  = C_ROW_W'(r_word - C_GRP);
            emit_bank = 1'b0;
        end else begin
            emit_row  = C_ROW_W'(r_word - C_GRP2);
            emit_bank = 1'b1;
        end
    end

    assign rd_row = (r_state == ST_EMIT_RD || r_state == ST_EMIT_LD) ? emit_row : r_row;

    always_comb begin
        emit_data = shown_rdata[emit_bank];
        if (r_word == C_TALLY_WD) begin
            emit_data[C_TALLY_LANE] = r_update_tally;
        end
    end

    always_comb begin
        frame_we    = '0;
        shown_we    = '0;
        wr_row      = r_row;
        frame_wdata = {(C_BANKS * C_LANES){C_CHAR_SPACE}};
        shown_wdata = frame_rdata;
        unique case (r_state)
            ST_INIT: begin
                frame_we    = '1;
                shown_we    = '1;
                shown_wdata = {(C_BANKS * C_LANES){C_CHAR_NUL}};
            end
            ST_IDLE: begin
                wr_row = smp_row;
                for (int l = 0; l < C_LANES; l++) begin
                    frame_wdata[0][l] = C_CHAR_ZERO + C_CHAR_W'(smp.digit_first);
                    frame_wdata[1][l] = C_CHAR_ZERO + C_CHAR_W'(smp.digit_second);
                end
                if (in_accept && smp_valid) begin
                    frame_we[0][smp_lane] = bcd_first;
                    frame_we[1][smp_lane] = bcd_second;
                end
            end
            ST_CMP_WR: begin
                frame_we = '1;
                shown_we = '1;
            end
            default: begin
            end
        endcase
    end

    for (genvar b = 0; b < C_BANKS; b++) begin : g_bank
        for (genvar l = 0; l < C_LANES; l++) begin : g_lane
            sbdc_ram #(
                .WIDTH (C_CHAR_W),
                .DEPTH (C_ROWS)
            ) u_frame (
                .i_clk   (i_clk),
                .i_we    (frame_we[b][l]),
                .i_waddr (wr_row),
                .i_wdata (frame_wdata[b][l]),
                .i_raddr (rd_row),
                .o_rdata (frame_rdata[b][l])
            );

            sbdc_ram #(
                .WIDTH (C_CHAR_W),
                .DEPTH (C_ROWS)
            ) u_shown (
                .i_clk   (i_clk),
                .i_we    (shown_we[b][l]),
                .i_waddr (wr_row),
                .i_wdata (shown_wdata[b][l]),
                .i_raddr (rd_row),
                .o_rdata (shown_rdata[b][l])
            );
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_INIT;
            r_row          <= '0;
            r_word         <= '0;
            r_diff         <= 1'b0;
            r_valid_prev   <= 1'b0;
            r_tally        <= '0;
            r_dirty        <= 1'b1;
            r_update_tally <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (o_word.ready && r_state != ST_EMIT_LD) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_INIT: begin
                    if (r_row == C_ROW_LAST) begin
                        r_row   <= '0;
                        r_state <= ST_IDLE;
                    end else begin
                        r_row <= r_row + 1'b1;
                    end
                end
                ST_IDLE: begin
                    if (in_accept) begin
                        r_valid_prev <= smp_valid;
                        if (smp_valid) begin
                            r_tally <= n_tally;
                            if (bcd_first || bcd_second) begin
                                r_dirty <= 1'b1;
                            end
                        end else if (r_dirty && n_tally > 8'd1) begin
                            r_dirty <= 1'b0;
                            r_tally <= '0;
                            r_row   <= '0;
                            r_diff  <= 1'b0;
                            r_state <= ST_CMP_RD;
                        end else begin
                            r_tally <= n_tally;
                        end
                    end
                end
                ST_CMP_RD: begin
                    r_state <= ST_CMP_WR;
                end
                ST_CMP_WR: begin
                    r_diff <= n_diff;
                    if (r_row == C_ROW_LAST) begin
                        r_row   <= '0;
                        r_word  <= '0;
                        r_state <= n_diff ? ST_EMIT_RD : ST_IDLE;
                    end else begin
                        r_row   <= r_row + 1'b1;
                        r_state <= ST_CMP_RD;
                    end
                end
                ST_EMIT_RD: begin
                    r_state <= ST_EMIT_LD;
                end
                ST_EMIT_LD: begin
                    if (out_free) begin
                        r_out_valid      <= 1'b1;
                        r_out.char_word  <= emit_data;
                        r_out.word_index <= r_word;
                        r_out.last_word  <= (r_word == C_WORD_LAST);
                        if (r_word == C_WORD_LAST) begin
                            r_update_tally <= r_update_tally + 1'b1;
                            r_state        <= ST_IDLE;
                        end else begin
                            r_word  <= r_word + 1'b1;
                            r_state <= ST_EMIT_RD;
                        end
                    end
                end
                default: begin
                    r_state <= ST_INIT;
                end
            endcase
        end
    end

endmodule

### src/sbdc_checker.sv
// ============================================================================
// sbdc_checker
// Port-level checks of the display capture block: word order, framing, stall hold and sample gating.
// ============================================================================
module sbdc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_char_word,
    input logic [4:0]  i_word_index,
    input logic        i_last_word
);
    import sbdc_pkg::*;

    logic [C_WORD_W-1:0] r_next_index;
    logic                out_accept;

    assign out_accept = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_index <= '0;
        end else if (out_accept) begin
            r_next_index <= i_last_word ? '0 : i_word_index + 1'b1;
        end
    end

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_char_word) && $stable(i_word_index)
            && $stable(i_last_word))
        else $error("stalled word changed");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_last_word == (i_word_index == C_WORD_LAST)))
        else $error("last flag does not match word index");

    a_word_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_accept |-> (i_word_index == r_next_index))
        else $error("word out of order");

    a_no_sample_mid_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_last_word |-> !i_in_ready)
        else $error("sample taken during frame emission");

endmodule

bind strobed_bcd_display_capture_top sbdc_checker u_sbdc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_sample.ready),
    .i_out_valid  (o_word.valid),
    .i_out_ready  (o_word.ready),
    .i_char_word  (o_word.data.char_word),
    .i_word_index (o_word.data.word_index),
    .i_last_word  (o_word.data.last_word)
);

### verif/sbdc_frame_checker.sv
// ============================================================================
// sbdc_frame_checker
// Watches the sample and word channels of the display capture block. It keeps
// its own copy of the frame, shown-frame and tally state, predicts the words
// that each accepted sample causes, and compares every accepted word with the
// oldest prediction.
// ============================================================================
module sbdc_frame_checker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_sample_valid,
    input  logic             i_sample_ready,
    input  sbdc_pkg::t_sample i_sample_data,
    input  logic             i_word_valid,
    input  logic             i_word_ready,
    input  sbdc_pkg::t_word  i_word_data,
    output int               o_mismatches,
    output int               o_pending
);
    import sbdc_pkg::*;

    logic [C_CHAR_W-1:0] frame_chars [C_FRAME_BYTES];
    logic [C_CHAR_W-1:0] shown_chars [C_FRAME_BYTES];
    logic                valid_prev;
    logic [7:0]          transition_tally;
    logic                frame_dirty;
    logic [7:0]          update_tally;

    t_word expected_words [$];

    task automatic reset_capture_state();
        for (int i = 0; i < C_FRAME_BYTES; i++) begin
            frame_chars[i] = C_CHAR_SPACE;
            shown_chars[i] = C_CHAR_NUL;
        end
        valid_prev       = 1'b0;
        transition_tally = 8'd0;
        frame_dirty      = 1'b1;
        update_tally     = 8'd0;
        expected_words.delete();
    endtask

    task automatic predict_frame_words(input t_sample s);
        logic                valid_now;
        logic [3:0]          pos_raw;
        int                  pos;
        logic                differs;
        logic [C_CHAR_W-1:0] sent [C_FRAME_BYTES];
        t_word               w;
        valid_now = !s.strobe_invalid;
        if (valid_now != valid_prev) begin
            transition_tally = transition_tally + 8'd1;
            valid_prev       = valid_now;
        end
        if (valid_now) begin
            pos_raw = 4'd15 - s.strobe_number;
            if (pos_raw == C_POS_LOW) begin
                pos = C_REMAP_LOW;
            end else if (pos_raw == C_POS_MID) begin
                pos = C_REMAP_MID;
            end else begin
                pos = int'(pos_raw);
            end
            if (s.digit_first < C_BCD_LIMIT) begin
                frame_chars[pos] = C_CHAR_ZERO + {4'd0, s.digit_first};
                frame_dirty      = 1'b1;
            end
            if (s.digit_second < C_BCD_LIMIT) begin
                frame_chars[pos + C_SECOND_OFS] = C_CHAR_ZERO + {4'd0, s.digit_second};
                frame_dirty                     = 1'b1;
            end
        end else if (frame_dirty && transition_tally > 8'd1) begin
            frame_dirty      = 1'b0;
            transition_tally = 8'd0;
            differs          = 1'b0;
            for (int i = 0; i < C_FRAME_BYTES; i++) begin
                if (frame_chars[i] != shown_chars[i]) begin
                    differs = 1'b1;
                end
            end
            if (differs) begin
                for (int i = 0; i < C_FRAME_BYTES; i++) begin
                    sent[i] = frame_chars[i];
                end
                sent[C_TALLY_BYTE] = update_tally;
                update_tally       = update_tally + 8'd1;
                for (int k = 0; k < C_WORDS; k++) begin
                    w.char_word  = {sent[4*k+3], sent[4*k+2], sent[4*k+1], sent[4*k]};
                    w.word_index = C_WORD_W'(k);
                    w.last_word  = (k == C_WORDS - 1);
                    expected_words.push_back(w);
                end
                for (int i = 0; i < C_FRAME_BYTES; i++) begin
                    shown_chars[i] = frame_chars[i];
                end
            end
            for (int i = 0; i < C_FRAME_BYTES; i++) begin
                frame_chars[i] = C_CHAR_SPACE;
            end
        end
    endtask

    task automatic check_word(input t_word got);
        t_word want;
        if (expected_words.size() == 0) begin
            if (o_mismatches < 10) begin
                $display("unexpected word: got %h idx %0d last %0d",
                         got.char_word, got.word_index, got.last_word);
            end
            o_mismatches = o_mismatches + 1;
        end else begin
            want = expected_words.pop_front();
            if (got.char_word !== want.char_word || got.word_index !== want.word_index
                    || got.last_word !== want.last_word) begin
                if (o_mismatches < 10) begin
                    $display({"word mismatch: expected %h idx %0d last %0d, ",
                              "got %h idx %0d last %0d"},
                             want.char_word, want.word_index, want.last_word,
                             got.char_word, got.word_index, got.last_word);
                end
                o_mismatches = o_mismatches + 1;
            end
        end
    endtask

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_capture_state();
        end else begin
            if (i_sample_valid && i_sample_ready) begin
                predict_frame_words(i_sample_data);
            end
            if (i_word_valid && i_word_ready) begin
                check_word(i_word_data);
            end
        end
        o_pending = expected_words.size();
    end

endmodule

### verif/strobed_bcd_display_capture_top_tb.sv
// ============================================================================
// strobed_bcd_display_capture_top_tb
// Drives display bus samples into the capture block: a directed set of
// remaps, digit limits and publish cases, then random scans, broken scans and
// noise. The sender runs in bursts, the receiver stalls on its own pattern
// with one long hold-off, and the frame checker judges every word.
// ============================================================================
module strobed_bcd_display_capture_top_tb;
    import sbdc_pkg::*;

    localparam int C_ITEMS = 460;

    logic i_clk;
    logic i_rst_n;
    int   mismatches;
    int   pending;

    sbdc_in_if  sample_ch ();
    sbdc_out_if word_ch ();

    t_sample    bus_samples [$];
    logic [3:0] scan_first  [16];
    logic [3:0] scan_second [16];
    bit         scan_known;

    strobed_bcd_display_capture_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (sample_ch.sink),
        .o_word   (word_ch.source)
    );

    sbdc_frame_checker checker_inst (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sample_valid (sample_ch.valid),
        .i_sample_ready (sample_ch.ready),
        .i_sample_data  (sample_ch.data),
        .i_word_valid   (word_ch.valid),
        .i_word_ready   (word_ch.ready),
        .i_word_data    (word_ch.data),
        .o_mismatches   (mismatches),
        .o_pending      (pending)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    initial begin
        i_rst_n = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        #400000;
        $display("tb: failure");
        $finish;
    end

    task automatic push_bus(input logic [3:0] strobe, input logic invalid,
                            input logic [3:0] d1, input logic [3:0] d2);
        t_sample s;
        s.strobe_number  = strobe;
        s.strobe_invalid = invalid;
        s.digit_first    = d1;
        s.digit_second   = d2;
        bus_samples.push_back(s);
    endtask

    function automatic logic [3:0] rand_digit();
        if ($urandom_range(0, 99) < 85) begin
            return 4'($urandom_range(0, 9));
        end
        return 4'($urandom_range(10, 15));
    endfunction

    task automatic add_gap(input int len);
        for (int i = 0; i < len; i++) begin
            push_bus(4'($urandom), 1'b1, 4'($urandom), 4'($urandom));
        end
    endtask

    // full multiplex scan, optionally repeating the previous digits
    task automatic add_scan(input bit same_digits);
        for (int s = 0; s < 16; s++) begin
            if (!same_digits || !scan_known) begin
                scan_first[s]  = rand_digit();
                scan_second[s] = rand_digit();
            end
            push_bus(4'(s), 1'b0, scan_first[s], scan_second[s]);
        end
        scan_known = 1'b1;
        add_gap($urandom_range(1, 4));
    endtask

    initial begin : sample_sender
        int idx;
        int burst;
        int gap;
        int pick;
        int len;
        sample_ch.valid = 1'b0;
        sample_ch.data  = '0;
        scan_known      = 1'b0;

        // remapped positions, digit extremes, non-BCD digits
        push_bus(4'd15, 1'b0, 4'd1, 4'd2);
        push_bus(4'd7,  1'b0, 4'd3, 4'd4);
        push_bus(4'd0,  1'b0, 4'd9, 4'd0);
        push_bus(4'd14, 1'b0, 4'd0, 4'd9);
        push_bus(4'd1,  1'b0, 4'd15, 4'd10);
        push_bus(4'd2,  1'b0, 4'd10, 4'd3);
        push_bus(4'd5,  1'b1, 4'd5, 4'd5);
        push_bus(4'd9,  1'b1, 4'd9, 4'd9);
        // same content again: publish with unchanged frame
        push_bus(4'd15, 1'b0, 4'd1, 4'd2);
        push_bus(4'd7,  1'b0, 4'd3, 4'd4);
        push_bus(4'd0,  1'b0, 4'd9, 4'd0);
        push_bus(4'd14, 1'b0, 4'd0, 4'd9);
        push_bus(4'd1,  1'b0, 4'd15, 4'd10);
        push_bus(4'd2,  1'b0, 4'd10, 4'd3);
        push_bus(4'd3,  1'b1, 4'd0, 4'd0);
        // ignored digits alone: nothing dirty, no publish; then real digits and a publish
        push_bus(4'd6,  1'b0, 4'd12, 4'd11);
        push_bus(4'd6,  1'b1, 4'd13, 4'd14);
        push_bus(4'd8,  1'b0, 4'd5, 4'd5);
        push_bus(4'd8,  1'b1, 4'd15, 4'd15);

        while (bus_samples.size() < C_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                add_scan($urandom_range(0, 3) == 0);
            end else if (pick < 85) begin
                len = $urandom_range(1, 15);
                for (int i = 0; i < len; i++) begin
                    push_bus(4'($urandom), $urandom_range(0, 5) == 0, rand_digit(), rand_digit());
                end
                add_gap($urandom_range(1, 3));
            end else begin
                len = $urandom_range(1, 8);
                for (int i = 0; i < len; i++) begin
                    push_bus(4'($urandom), 1'($urandom), 4'($urandom), 4'($urandom));
                end
            end
        end

        wait (i_rst_n);
        @(negedge i_clk);
        idx = 0;
        while (idx < bus_samples.size()) begin
            burst = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 20);
            for (int b = 0; b < burst && idx < bus_samples.size(); b++) begin
                sample_ch.valid <= 1'b1;
                sample_ch.data  <= bus_samples[idx];
                @(posedge i_clk);
                while (!sample_ch.ready) @(posedge i_clk);
                idx++;
                @(negedge i_clk);
            end
            gap = $urandom_range(0, 6);
            if (gap > 0 || idx == bus_samples.size()) begin
                sample_ch.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end

        while (pending != 0) @(negedge i_clk);
        repeat (80) @(negedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin : word_receiver
        int  cycles;
        int  mode;
        int  seg_len;
        int  period;
        bit  held_off;
        word_ch.ready = 1'b0;
        cycles        = 0;
        held_off      = 1'b0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            // hold off once for a long stretch so the block backs up
            if (!held_off && cycles > 600) begin
                held_off = 1'b1;
                word_ch.ready <= 1'b0;
                repeat (400) @(negedge i_clk);
                cycles += 400;
            end
            mode    = $urandom_range(0, 2);
            seg_len = $urandom_range(10, 120);
            period  = $urandom_range(2, 5);
            for (int j = 0; j < seg_len; j++) begin
                case (mode)
                    0: begin
                        word_ch.ready <= 1'b1;
                    end
                    1: begin
                        word_ch.ready <= 1'($urandom_range(0, 1));
                    end
                    default: begin
                        word_ch.ready <= (j % period) != 0;
                    end
                endcase
                @(negedge i_clk);
                cycles++;
            end
        end
    end

endmodule
